FILE: design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Operation codes and fixed result widths for the reversible ring stack.
// ----------------------------------------------------------------------------
package rrs_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_FLIP = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned USED_W = 5;

endpackage

FILE: design/reversible_ring_stack.sv
// ----------------------------------------------------------------------------
// reversible_ring_stack
// LIFO stack in a circular store with push, pop and whole-stack reversal.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------
//  input    | in_mode, in_push_value                  | start && !busy
//  result   | out_pop_value, out_accepted, out_depth_ | out_valid, one cycle
//           | used, out_now_empty/full/reversed       |
//
//  One item per cycle; its result appears in the cycle after acceptance.
//  The figure is set by the single slot store: one write (push) or one
//  registered read (pop) per item at the accepting edge.
//  busy is held low; the receiver cannot stall and none is needed.
//  Synchronous reset clears pointers, count and direction; slot contents
//  are undefined until pushed.
// ----------------------------------------------------------------------------
module reversible_ring_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [rrs_pkg::VAL_W-1:0]     in_push_value,
  output logic                          out_valid,
  output logic [rrs_pkg::VAL_W-1:0]     out_pop_value,
  output logic                          out_accepted,
  output logic [rrs_pkg::USED_W-1:0]    out_depth_used,
  output logic                          out_now_empty,
  output logic                          out_now_full,
  output logic                          out_now_reversed
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];

  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] bot_r, bot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;

  logic          vld_r;
  logic          ok_r, ok_nxt;
  logic          pop_r, pop_nxt;
  logic [WIDTH-1:0] rd_r;

  logic          acc;
  logic          wr_en;
  logic [AW-1:0] up_ptr, dn_ptr;
  logic [WIDTH-1:0] wr_data;
  logic [WIDTH+rrs_pkg::VAL_W-1:0] push_ext;
  logic [WIDTH+rrs_pkg::VAL_W-1:0] pop_ext;
  logic [CW+rrs_pkg::USED_W-1:0]   used_ext;
  rrs_pkg::mode_t mode;

  assign busy  = 1'b0;
  assign acc   = start && !busy;
  assign mode  = rrs_pkg::mode_t'(in_mode);

  assign up_ptr = (top_r == LAST_SLOT) ? '0 : top_r + AW'(1);
  assign dn_ptr = (top_r == '0) ? LAST_SLOT : top_r - AW'(1);

  assign push_ext = {{WIDTH{1'b0}}, in_push_value};
  assign wr_data  = push_ext[WIDTH-1:0];

  always_comb begin
    top_nxt = top_r;
    bot_nxt = bot_r;
    cnt_nxt = cnt_r;
    rev_nxt = rev_r;
    ok_nxt  = 1'b0;
    pop_nxt = 1'b0;
    wr_en   = 1'b0;
    if (acc) begin
      unique case (mode)
        rrs_pkg::MODE_PUSH: begin
          if (cnt_r != FULL_CNT) begin
            if (cnt_r == '0) begin
              bot_nxt = top_r;
            end else begin
              top_nxt = rev_r ? dn_ptr : up_ptr;
            end
            cnt_nxt = cnt_r + CW'(1);
            wr_en   = 1'b1;
            ok_nxt  = 1'b1;
          end
        end
        rrs_pkg::MODE_POP: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CW'(1);
            if (cnt_r != CW'(1)) begin
              top_nxt = rev_r ? up_ptr : dn_ptr;
            end
            pop_nxt = 1'b1;
            ok_nxt  = 1'b1;
          end
        end
        rrs_pkg::MODE_FLIP: begin
          top_nxt = bot_r;
          bot_nxt = top_r;
          rev_nxt = !rev_r;
          ok_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[top_nxt] <= wr_data;
    end
    rd_r <= slots[top_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      bot_r <= '0;
      cnt_r <= '0;
      rev_r <= 1'b0;
      vld_r <= 1'b0;
      ok_r  <= 1'b0;
      pop_r <= 1'b0;
    end else begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      cnt_r <= cnt_nxt;
      rev_r <= rev_nxt;
      vld_r <= acc;
      ok_r  <= ok_nxt;
      pop_r <= pop_nxt;
    end
  end

  assign pop_ext  = {{rrs_pkg::VAL_W{1'b0}}, (pop_r ? rd_r : {WIDTH{1'b0}})};
  assign used_ext = {{rrs_pkg::USED_W{1'b0}}, cnt_r};

  assign out_valid        = vld_r;
  assign out_pop_value    = pop_ext[rrs_pkg::VAL_W-1:0];
  assign out_accepted     = ok_r;
  assign out_depth_used   = used_ext[rrs_pkg::USED_W-1:0];
  assign out_now_empty    = (cnt_r == '0);
  assign out_now_full     = (cnt_r == FULL_CNT);
  assign out_now_reversed = rev_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("item count beyond capacity");

  a_single_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(1)) |-> (top_r == bot_r))
    else $error("top and bottom differ with at most one item");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted item gave no result");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_pop_value == '0))
    else $error("refused item carries a value");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && mode == rrs_pkg::MODE_POP && cnt_r != '0) |=>
      (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not reduce the count");
`endif

endmodule
